### rtl/rgb_lcd_timing_generator_top_defines.svh
// ----------------------------------------------------------------------------
// RGB LCD timing generator assertion macros
// Shared macros for the concurrent checks of the timing generator.
// ----------------------------------------------------------------------------
`ifndef RGB_LCD_TIMING_GENERATOR_TOP_DEFINES_SVH
`define RGB_LCD_TIMING_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication check.
`define RLTG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define RLTG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rltg_pkg.sv
// ----------------------------------------------------------------------------
// RGB LCD timing generator package
// Register codes, reset values, command codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rltg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_HSYNC_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DE_START    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_VSYNC_LINES = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BLANK_LINES = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DUMMY_LINES = 3'd6;

   localparam logic [7:0] RST_HSYNC_WIDTH = 8'd11;
   localparam logic [9:0] RST_LINE_LENGTH = 10'd429;
   localparam logic [9:0] RST_DE_START    = 10'd42;
   localparam logic [7:0] RST_PAD_WIDTH   = 8'd62;
   localparam logic [5:0] RST_VSYNC_LINES = 6'd3;
   localparam logic [5:0] RST_BLANK_LINES = 6'd3;
   localparam logic [5:0] RST_DUMMY_LINES = 6'd22;

   // Upper bounds of the register sums used to size the counters.
   localparam int MAX_SETUP_LINES = 4 * 63;
   localparam int MAX_DE_REACH    = 1023 + 2 * 255;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam int RED_LSB   = 11;
   localparam int GREEN_LSB = 5;
   localparam int BLUE_LSB  = 0;

   typedef struct packed {
      logic [7:0] hsync_width;
      logic [9:0] line_length;
      logic [9:0] de_start;
      logic [7:0] pad_width;
      logic [5:0] vsync_lines;
      logic [5:0] blank_lines;
      logic [5:0] dummy_lines;
   } cfg_type;

   typedef struct packed {
      logic hsync;
      logic vsync;
      logic data_enable;
      logic active;
   } flags_type;

endpackage

### rtl/rltg_ifs.sv
// ----------------------------------------------------------------------------
// RGB LCD timing generator channel interfaces
// Valid/ready channels for command transactions and pixel responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rltg_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] pixel_address;
   logic [15:0] pixel_value;

   modport source (output valid, cmd, pixel_address, pixel_value, input ready);
   modport sink (input valid, cmd, pixel_address, pixel_value, output ready);
endinterface

interface rltg_rsp_if;
   logic       valid;
   logic       ready;
   logic       hsync;
   logic       vsync;
   logic       data_enable;
   logic [4:0] red;
   logic [5:0] green;
   logic [4:0] blue;

   modport source (output valid, hsync, vsync, data_enable, red, green, blue,
                   input ready);
   modport sink (input valid, hsync, vsync, data_enable, red, green, blue,
                 output ready);
endinterface

### rtl/rltg_timing.sv
// ----------------------------------------------------------------------------
// RGB LCD timing generator counters
// Column and line counters with the sync, enable and active-area decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rltg_timing #(
   parameter int ACTIVE_WIDTH = 196,
   parameter int ACTIVE_LINES = 196,
   parameter int ROW_W        = 8,
   parameter int X_W          = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  rltg_pkg::cfg_type   cfg,
   input  logic                advance,
   output rltg_pkg::flags_type flags,
   output logic [ROW_W-1:0]    row,
   output logic [X_W-1:0]      x
);
   import rltg_pkg::*;

   localparam int LINE_W = $clog2(MAX_SETUP_LINES + ACTIVE_LINES + 1);
   localparam int H_W    = $clog2(MAX_DE_REACH + ACTIVE_WIDTH + 1);

   logic [9:0]        col_ff, col_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LINE_W-1:0] d0, a0, a1, d1, row_full;
   logic [H_W-1:0]    col_h, de_lo, act_lo, act_hi, de_hi, x_full;
   logic              de_line, act_line, in_de;

   always_comb begin
      d0 = LINE_W'(cfg.vsync_lines) + LINE_W'(cfg.blank_lines);
      a0 = d0 + LINE_W'(cfg.dummy_lines);
      a1 = a0 + LINE_W'(ACTIVE_LINES);
      d1 = a1 + LINE_W'(cfg.dummy_lines);
      de_line  = (line_ff >= d0) && (line_ff < d1);
      act_line = (line_ff >= a0) && (line_ff < a1);

      col_h  = H_W'(col_ff);
      de_lo  = H_W'(cfg.de_start);
      act_lo = de_lo + H_W'(cfg.pad_width);
      act_hi = act_lo + H_W'(ACTIVE_WIDTH);
      de_hi  = act_hi + H_W'(cfg.pad_width);
      in_de  = de_line && (col_h >= de_lo) && (col_h < de_hi);

      flags.hsync       = col_ff >= 10'(cfg.hsync_width);
      flags.vsync       = line_ff >= LINE_W'(cfg.vsync_lines);
      flags.data_enable = in_de;
      flags.active      = in_de && act_line && (col_h >= act_lo) && (col_h < act_hi);

      row_full = line_ff - a0;
      x_full   = col_h - act_lo;
      row      = row_full[ROW_W-1:0];
      x        = x_full[X_W-1:0];

      col_in  = col_ff;
      line_in = line_ff;
      if (advance) begin
         if (({1'b0, col_ff} + 11'd1) >= {1'b0, cfg.line_length}) begin
            col_in = '0;
            if (((LINE_W+1)'(line_ff) + (LINE_W+1)'(1)) >= (LINE_W+1)'(d1)) begin
               line_in = '0;
            end else begin
               line_in = line_ff + LINE_W'(1);
            end
         end else begin
            col_in = col_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

endmodule

### rtl/rltg_fbuf.sv
// ----------------------------------------------------------------------------
// RGB LCD timing generator frame buffer
// Single-write, single-read pixel memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rltg_fbuf #(
   parameter int DEPTH  = 38416,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rgb_lcd_timing_generator_top.sv
// ----------------------------------------------------------------------------
// RGB LCD timing generator
// Parallel RGB565 panel timing with a local frame buffer.
//
//   Channel   Direction  Carries
//   req_bus   in         pixel write or one pixel-clock tick
//   rsp_bus   out        HSYNC, VSYNC, DE and RGB for each tick
//   csr_*     in         timing register writes
//
// One transaction is accepted per cycle while no response is held; a tick's
// response passes through the decode stage, the address multiply and the
// registered frame-buffer read.
// Synchronous reset clears the counters and pipeline and restores register
// defaults; the frame buffer is not cleared and must be loaded before display.
// A held response stalls the whole pipeline and the input side together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_lcd_timing_generator_top_defines.svh"

module rgb_lcd_timing_generator_top #(
   parameter int ACTIVE_WIDTH = 196,
   parameter int ACTIVE_LINES = 196
) (
   input  logic                             clock,
   input  logic                             reset,
   rltg_req_if.sink                         req_bus,
   rltg_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [rltg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rltg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rltg_pkg::*;

   localparam int FB_DEPTH = ACTIVE_WIDTH * ACTIVE_LINES;
   localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
   localparam int ROW_W    = (ACTIVE_LINES > 1) ? $clog2(ACTIVE_LINES) : 1;
   localparam int X_W      = (ACTIVE_WIDTH > 1) ? $clog2(ACTIVE_WIDTH) : 1;

   cfg_type           cfg_ff, cfg_in;
   flags_type         t_flags;
   logic [ROW_W-1:0]  t_row;
   logic [X_W-1:0]    t_x;

   logic              adv, accept, tick;
   logic              wr_en;
   logic [FB_AW+15:0] wr_addr_ext;
   logic [FB_AW-1:0]  rd_addr;
   logic              rd_en;
   logic [15:0]       rd_data;

   logic              s1_valid_ff;
   flags_type         s1_flags_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [X_W-1:0]    s1_x_ff;
   logic              s2_valid_ff;
   flags_type         s2_flags_ff;

   logic              rsp_valid_ff;
   logic              rsp_hsync_ff, rsp_vsync_ff, rsp_de_ff;
   logic [4:0]        rsp_red_ff, rsp_blue_ff;
   logic [5:0]        rsp_green_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HSYNC_WIDTH: cfg_in.hsync_width = csr_wdata[7:0];
            REG_LINE_LENGTH: cfg_in.line_length = csr_wdata[9:0];
            REG_DE_START:    cfg_in.de_start    = csr_wdata[9:0];
            REG_PAD_WIDTH:   cfg_in.pad_width   = csr_wdata[7:0];
            REG_VSYNC_LINES: cfg_in.vsync_lines = csr_wdata[5:0];
            REG_BLANK_LINES: cfg_in.blank_lines = csr_wdata[5:0];
            REG_DUMMY_LINES: cfg_in.dummy_lines = csr_wdata[5:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hsync_width <= RST_HSYNC_WIDTH;
         cfg_ff.line_length <= RST_LINE_LENGTH;
         cfg_ff.de_start    <= RST_DE_START;
         cfg_ff.pad_width   <= RST_PAD_WIDTH;
         cfg_ff.vsync_lines <= RST_VSYNC_LINES;
         cfg_ff.blank_lines <= RST_BLANK_LINES;
         cfg_ff.dummy_lines <= RST_DUMMY_LINES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;
   assign tick          = accept && (req_bus.cmd == CMD_TICK);

   assign wr_addr_ext = (FB_AW+16)'(req_bus.pixel_address);
   assign wr_en       = accept && (req_bus.cmd == CMD_WRITE)
                        && ({16'd0, req_bus.pixel_address} < 32'(FB_DEPTH));

   assign rd_addr = FB_AW'(s1_row_ff) * FB_AW'(ACTIVE_WIDTH) + FB_AW'(s1_x_ff);
   assign rd_en   = adv && s1_valid_ff && s1_flags_ff.active;

   rltg_timing #(
      .ACTIVE_WIDTH (ACTIVE_WIDTH),
      .ACTIVE_LINES (ACTIVE_LINES),
      .ROW_W        (ROW_W),
      .X_W          (X_W)
   ) u_timing (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (tick),
      .flags   (t_flags),
      .row     (t_row),
      .x       (t_x)
   );

   rltg_fbuf #(
      .DEPTH  (FB_DEPTH),
      .ADDR_W (FB_AW)
   ) u_fbuf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_ext[FB_AW-1:0]),
      .wr_data (req_bus.pixel_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= tick;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_flags_ff  <= t_flags;
         s1_row_ff    <= t_row;
         s1_x_ff      <= t_x;
         s2_flags_ff  <= s1_flags_ff;
         rsp_hsync_ff <= s2_flags_ff.hsync;
         rsp_vsync_ff <= s2_flags_ff.vsync;
         rsp_de_ff    <= s2_flags_ff.data_enable;
         if (s2_flags_ff.active) begin
            rsp_red_ff   <= rd_data[RED_LSB +: 5];
            rsp_green_ff <= rd_data[GREEN_LSB +: 6];
            rsp_blue_ff  <= rd_data[BLUE_LSB +: 5];
         end else begin
            rsp_red_ff   <= '0;
            rsp_green_ff <= '0;
            rsp_blue_ff  <= '0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hsync       = rsp_hsync_ff;
   assign rsp_bus.vsync       = rsp_vsync_ff;
   assign rsp_bus.data_enable = rsp_de_ff;
   assign rsp_bus.red         = rsp_red_ff;
   assign rsp_bus.green       = rsp_green_ff;
   assign rsp_bus.blue        = rsp_blue_ff;

   `RLTG_ASSERT_NXT(a_tick_enters, clock, reset, req_bus.valid && req_bus.ready && req_bus.cmd == CMD_TICK, s1_valid_ff, "Accepted tick did not enter the pipeline.")
   `RLTG_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_bus.ready, "Input stalled while the response register is empty.")
   `RLTG_ASSERT_NXT(a_s2_drains, clock, reset, s2_valid_ff && adv, rsp_valid_ff, "Pipeline transaction was lost before the response register.")

endmodule

### verif/rgb_lcd_timing_generator_top_tb.sv
// ----------------------------------------------------------------------------
// RGB LCD timing generator testbench
// Drives pixel writes and pixel-clock ticks into the timing generator and
// checks every response against a cycle-free prediction of the raster scan:
// HSYNC, VSYNC, DE and the RGB565 color read back from the frame buffer.
// Timing registers are changed between phases, from both extremes to small
// random frames, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_lcd_timing_generator_top_tb;
   import rltg_pkg::*;

   localparam int ACTIVE_WIDTH = 196;
   localparam int ACTIVE_LINES = 196;
   localparam int FB_DEPTH = ACTIVE_WIDTH * ACTIVE_LINES;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT = 40000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic        cmd;
      logic [15:0] pixel_address;
      logic [15:0] pixel_value;
   } lcd_cmd_type;

   typedef struct packed {
      logic       hsync;
      logic       vsync;
      logic       data_enable;
      logic [4:0] red;
      logic [5:0] green;
      logic [4:0] blue;
   } panel_pixel_type;

   typedef struct {
      int unsigned col;
      int unsigned line;
   } raster_type;

   typedef struct {
      bit          vsync;
      bit          de;
      bit          fetch;
      int unsigned index;
   } scan_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rltg_req_if req_bus ();
   rltg_rsp_if rsp_bus ();

   rgb_lcd_timing_generator_top #(
      .ACTIVE_WIDTH(ACTIVE_WIDTH),
      .ACTIVE_LINES(ACTIVE_LINES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Prediction state.
   cfg_type         timing_cfg;
   raster_type      scan_pos;
   logic [15:0]     frame_mem [FB_DEPTH];
   panel_pixel_type pixel_expect_q [$];

   // Stimulus planning state.
   raster_type  plan_pos;
   bit          pixel_loaded [FB_DEPTH];
   lcd_cmd_type cmd_q [$];

   lcd_cmd_type req_item;
   lcd_cmd_type accepted_item;
   bit          req_taken;
   bit          rsp_taken;
   bit          req_quiet;
   bit          rsp_quiet;
   int          gap_left;
   int          stall_left;

   int mismatch_count;
   int responses_checked;
   int writes_accepted;
   int ticks_accepted;
   int settings_run;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout: the run did not complete.");
      $display("simulation failed");
      $finish;
   end

   function automatic cfg_type make_timing(int hs, int ll, int ds, int pad, int vs, int bl,
                                           int dm);
      cfg_type c;
      c.hsync_width = 8'(hs);
      c.line_length = 10'(ll);
      c.de_start = 10'(ds);
      c.pad_width = 8'(pad);
      c.vsync_lines = 6'(vs);
      c.blank_lines = 6'(bl);
      c.dummy_lines = 6'(dm);
      return c;
   endfunction

   function automatic scan_type scan_decode(cfg_type c, raster_type p);
      int unsigned d0, a0, a1, d1, act_lo, act_hi, de_hi;
      scan_type s;
      d0 = c.vsync_lines + c.blank_lines;
      a0 = d0 + c.dummy_lines;
      a1 = a0 + ACTIVE_LINES;
      d1 = a1 + c.dummy_lines;
      act_lo = c.de_start + c.pad_width;
      act_hi = act_lo + ACTIVE_WIDTH;
      de_hi = act_hi + c.pad_width;
      s.vsync = p.line >= c.vsync_lines;
      s.de = p.line >= d0 && p.line < d1 && p.col >= c.de_start && p.col < de_hi;
      s.fetch = s.de && p.line >= a0 && p.line < a1 && p.col >= act_lo && p.col < act_hi;
      s.index = s.fetch ? (p.line - a0) * ACTIVE_WIDTH + (p.col - act_lo) : 0;
      return s;
   endfunction

   function automatic raster_type raster_advance(cfg_type c, raster_type p);
      int unsigned frame_len;
      frame_len = c.vsync_lines + c.blank_lines + 2 * c.dummy_lines + ACTIVE_LINES;
      if (p.col + 1 >= c.line_length) begin
         p.col = 0;
         p.line = (p.line + 1 >= frame_len) ? 0 : p.line + 1;
      end else begin
         p.col = p.col + 1;
      end
      return p;
   endfunction

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic predict_transaction(lcd_cmd_type t);
      scan_type        s;
      panel_pixel_type px;
      logic [15:0]     word;
      if (t.cmd == CMD_WRITE) begin
         if (t.pixel_address < FB_DEPTH) frame_mem[t.pixel_address] = t.pixel_value;
         writes_accepted++;
      end else begin
         s = scan_decode(timing_cfg, scan_pos);
         word = s.fetch ? frame_mem[s.index] : 16'h0000;
         px.hsync = scan_pos.col >= timing_cfg.hsync_width;
         px.vsync = s.vsync;
         px.data_enable = s.de;
         px.red = word[RED_LSB +: 5];
         px.green = word[GREEN_LSB +: 6];
         px.blue = word[BLUE_LSB +: 5];
         pixel_expect_q.push_back(px);
         scan_pos = raster_advance(timing_cfg, scan_pos);
         ticks_accepted++;
      end
   endtask

   task automatic compare_field(string name, logic [5:0] got, logic [5:0] want);
      if (got !== want)
         flag_mismatch($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                                 responses_checked, name, got, want));
   endtask

   task automatic check_pixel();
      panel_pixel_type want;
      if (pixel_expect_q.size() == 0) begin
         flag_mismatch("response with no pending tick");
      end else begin
         want = pixel_expect_q.pop_front();
         compare_field("hsync", rsp_bus.hsync, want.hsync);
         compare_field("vsync", rsp_bus.vsync, want.vsync);
         compare_field("data_enable", rsp_bus.data_enable, want.data_enable);
         compare_field("red", rsp_bus.red, want.red);
         compare_field("green", rsp_bus.green, want.green);
         compare_field("blue", rsp_bus.blue, want.blue);
      end
      responses_checked++;
   endtask

   task automatic plan_write(logic [15:0] addr, logic [15:0] value);
      lcd_cmd_type t;
      t.cmd = CMD_WRITE;
      t.pixel_address = addr;
      t.pixel_value = value;
      cmd_q.push_back(t);
      if (addr < FB_DEPTH) pixel_loaded[addr] = 1'b1;
   endtask

   // A tick that would show a never-loaded pixel is preceded by a write to it.
   task automatic plan_tick();
      scan_type    s;
      lcd_cmd_type t;
      s = scan_decode(timing_cfg, plan_pos);
      if (s.fetch && !pixel_loaded[s.index]) plan_write(16'(s.index), 16'($urandom));
      t.cmd = CMD_TICK;
      t.pixel_address = 16'($urandom);
      t.pixel_value = 16'($urandom);
      cmd_q.push_back(t);
      plan_pos = raster_advance(timing_cfg, plan_pos);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_HSYNC_WIDTH: timing_cfg.hsync_width = 8'(value);
         REG_LINE_LENGTH: timing_cfg.line_length = 10'(value);
         REG_DE_START:    timing_cfg.de_start = 10'(value);
         REG_PAD_WIDTH:   timing_cfg.pad_width = 8'(value);
         REG_VSYNC_LINES: timing_cfg.vsync_lines = 6'(value);
         REG_BLANK_LINES: timing_cfg.blank_lines = 6'(value);
         REG_DUMMY_LINES: timing_cfg.dummy_lines = 6'(value);
         default: ;
      endcase
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while ((cmd_q.size() != 0 || req_bus.valid || pixel_expect_q.size() != 0) &&
             waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (cmd_q.size() != 0 || req_bus.valid || pixel_expect_q.size() != 0) begin
         flag_mismatch($sformatf("%0d transactions unsent and %0d responses missing",
                                 cmd_q.size(), pixel_expect_q.size()));
         pixel_expect_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(cfg_type c, int count, int tick_pct);
      logic [15:0] addr;
      csr_write(REG_HSYNC_WIDTH, c.hsync_width);
      csr_write(REG_LINE_LENGTH, c.line_length);
      csr_write(REG_DE_START, c.de_start);
      csr_write(REG_PAD_WIDTH, c.pad_width);
      csr_write(REG_VSYNC_LINES, c.vsync_lines);
      csr_write(REG_BLANK_LINES, c.blank_lines);
      csr_write(REG_DUMMY_LINES, c.dummy_lines);
      settings_run++;
      req_quiet = $urandom_range(3) == 0;
      rsp_quiet = $urandom_range(3) == 0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < tick_pct) begin
            plan_tick();
         end else begin
            case ($urandom_range(2))
               0: addr = 16'($urandom_range(ACTIVE_LINES - 1) * ACTIVE_WIDTH +
                             $urandom_range(31));
               1: addr = 16'($urandom_range(FB_DEPTH - 1));
               default: addr = 16'($urandom);
            endcase
            plan_write(addr, 16'($urandom));
         end
      end
      drain();
   endtask

   function automatic cfg_type pick_timing(bit wide);
      if (wide)
         return make_timing($urandom_range(1, 255), $urandom_range(2, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 255),
                            $urandom_range(1, 63), $urandom_range(0, 63),
                            $urandom_range(0, 63));
      return make_timing($urandom_range(1) ? $urandom_range(1, 255) : $urandom_range(1, 6),
                         $urandom_range(2, 24), $urandom_range(0, 12),
                         $urandom_range(3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 4),
                         $urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(0, 3));
   endfunction

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (cmd_q.size() != 0) begin
            req_item = cmd_q.pop_front();
            req_bus.cmd <= req_item.cmd;
            req_bus.pixel_address <= req_item.pixel_address;
            req_bus.pixel_value <= req_item.pixel_value;
            req_bus.valid <= 1'b1;
            gap_left = req_quiet ? 0 : $urandom_range(0, 7);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response sink with random back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_taken) stall_left = rsp_quiet ? 0 : $urandom_range(0, 7);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Transaction monitor for both channels.
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      rsp_taken <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            accepted_item.cmd = req_bus.cmd;
            accepted_item.pixel_address = req_bus.pixel_address;
            accepted_item.pixel_value = req_bus.pixel_value;
            predict_transaction(accepted_item);
         end
         if (rsp_bus.valid && rsp_bus.ready) check_pixel();
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_WRITE;
      req_bus.pixel_address = '0;
      req_bus.pixel_value = '0;
      rsp_bus.ready = 1'b0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      timing_cfg = make_timing(RST_HSYNC_WIDTH, RST_LINE_LENGTH, RST_DE_START, RST_PAD_WIDTH,
                               RST_VSYNC_LINES, RST_BLANK_LINES, RST_DUMMY_LINES);
      scan_pos = '{col: 0, line: 0};
      plan_pos = '{col: 0, line: 0};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: color extremes, the last address, writes past the
      // buffer that must be dropped, and the HSYNC edge of the first line.
      plan_write(16'd0, 16'hF800);
      plan_write(16'd1, 16'h07E0);
      plan_write(16'(ACTIVE_WIDTH), 16'h001F);
      plan_write(16'(ACTIVE_WIDTH + 1), 16'hFFFF);
      plan_write(16'(FB_DEPTH - 1), 16'h0000);
      plan_write(16'(FB_DEPTH), 16'h5A5A);
      plan_write(16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 13; i++) plan_tick();
      drain();

      // Smallest legal frame; the column left over from the defaults is past
      // the new line length.
      run_phase(make_timing(1, 2, 0, 0, 1, 0, 0), 150, 70);
      // Largest register values; the DE window never opens inside the line.
      run_phase(make_timing(255, 1023, 1023, 255, 63, 63, 63), 60, 80);
      // One-column lines deep into the longest frame.
      run_phase(make_timing(1, 1, 0, 1, 63, 63, 63), 320, 95);
      // The frame shrinks below the current line, which must run as blank.
      run_phase(make_timing(2, 3, 0, 0, 1, 0, 0), 150, 75);
      for (int p = 0; p < 6; p++) run_phase(pick_timing(p == 2), 75, 70);

      $display("Checked %0d pixel responses from %0d ticks, with %0d frame buffer writes.",
               responses_checked, ticks_accepted, writes_accepted);
      $display("Ran %0d timing settings, both register extremes and mid-frame changes.",
               settings_run);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
